FILE: rtl/core/dlrd_pkg.sv
`timescale 1ns / 1ps
package dlrd_pkg;
  localparam int unsigned StackDepth  = 64;
  localparam int unsigned WorkerSlots = 4;
  localparam int unsigned CntW        = $clog2(StackDepth + 1);
  localparam int unsigned SlotW       = 2;

  localparam logic [2:0] CmdTile   = 3'd0;
  localparam logic [2:0] CmdMarker = 3'd1;
  localparam logic [2:0] CmdFinish = 3'd2;
  localparam logic [2:0] CmdError  = 3'd3;
  localparam logic [2:0] CmdCancel = 3'd4;
  localparam logic [2:0] CmdClear  = 3'd5;

  localparam logic [2:0] KindReceived  = 3'd0;
  localparam logic [2:0] KindCancelled = 3'd1;
  localparam logic [2:0] KindError     = 3'd2;
  localparam logic [2:0] KindJobDone   = 3'd3;
  localparam logic [2:0] KindStarted   = 3'd4;
  localparam logic [2:0] KindRejected  = 3'd5;

  typedef struct packed {
    logic        marker;
    logic [4:0]  zoom;
    logic [21:0] x;
    logic [21:0] y;
    logic [7:0]  client;
  } entry_t;

  // Stack control broadcast to every cell.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t din;
  } stk_ctrl_t;
endpackage

FILE: rtl/core/dlrd_stack_cell.sv
`timescale 1ns / 1ps
// One stack position: shifts down on push, up on pop, and compares its tile.
module dlrd_stack_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlrd_pkg::stk_ctrl_t ctrl_i,
  input  dlrd_pkg::entry_t    above_i,
  input  logic                above_vld_i,
  input  dlrd_pkg::entry_t    below_i,
  input  logic                below_vld_i,
  input  logic                clear_i,
  input  logic [21:0]         x_i,
  input  logic [21:0]         y_i,
  input  logic [4:0]          zoom_i,
  output dlrd_pkg::entry_t    ent_o,
  output logic                vld_o,
  output logic                hit_o
);
  dlrd_pkg::entry_t ent_q, ent_d;
  logic vld_q, vld_d;

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (ctrl_i.push) begin
      ent_d = above_i;
      vld_d = above_vld_i;
    end else if (ctrl_i.pop) begin
      ent_d = below_i;
      vld_d = below_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign vld_o = vld_q;
  assign hit_o = vld_q && !ent_q.marker && ent_q.x == x_i && ent_q.y == y_i
                 && ent_q.zoom == zoom_i;
endmodule

FILE: rtl/core/dlrd_stack.sv
`timescale 1ns / 1ps
// Row of cells; cell 0 is the top of stack.
module dlrd_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlrd_pkg::stk_ctrl_t ctrl_i,
  input  logic                clear_i,
  input  logic [21:0]         x_i,
  input  logic [21:0]         y_i,
  input  logic [4:0]          zoom_i,
  output dlrd_pkg::entry_t    top_o,
  output logic                hit_o
);
  localparam int unsigned N = dlrd_pkg::StackDepth;
  dlrd_pkg::entry_t ent [N];
  logic [N-1:0] vld, hit;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dlrd_pkg::entry_t ab, be;
    logic av, bv;
    if (i == 0) begin : g_top
      assign ab = ctrl_i.din;
      assign av = 1'b1;
    end else begin : g_mid
      assign ab = ent[i-1];
      assign av = vld[i-1];
    end
    if (i == N - 1) begin : g_bot
      assign be = ent[i];
      assign bv = 1'b0;
    end else begin : g_up
      assign be = ent[i+1];
      assign bv = vld[i+1];
    end
    dlrd_stack_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i,
      .above_i(ab), .above_vld_i(av), .below_i(be), .below_vld_i(bv),
      .clear_i, .x_i, .y_i, .zoom_i,
      .ent_o(ent[i]), .vld_o(vld[i]), .hit_o(hit[i])
    );
  end

  assign top_o = ent[0];
  assign hit_o = |hit;
endmodule

FILE: rtl/core/dedup_lifo_request_dispatcher_core.sv
`timescale 1ns / 1ps
// A beat is taken only in the idle state. Reject, finish, error and cancel
// results are registered and shown from the output state; a dispatch after a
// push passes the dispatch state first, one after a finish follows that result.
// A new beat waits until all results of the previous one have been taken.
// The stack is a row of shift cells; a push or a pop moves all of them at once.
// Reset clears stack count, slot state and the received counter at once.
module dedup_lifo_request_dispatcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [2:0]  command_i,
  input  logic [21:0] tile_x_i,
  input  logic [21:0] tile_y_i,
  input  logic [4:0]  zoom_i,
  input  logic [7:0]  requester_i,
  input  logic [1:0]  slot_index_i,
  input  logic [15:0] fault_code_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  client_o,
  output logic [1:0]  worker_o,
  output logic [21:0] out_x_o,
  output logic [21:0] out_y_o,
  output logic [4:0]  out_zoom_o,
  output logic [15:0] out_code_o,
  output logic [31:0] received_total_o,
  output logic        last_o
);
  localparam int unsigned NS = dlrd_pkg::WorkerSlots;
  localparam int unsigned CW = dlrd_pkg::CntW;

  typedef enum logic [1:0] {
    StIdle,
    StDispatch,
    StOut
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q;
  logic [NS-1:0] alloc_q, busy_q;
  dlrd_pkg::entry_t slot_tile_q [NS];
  logic [31:0] recv_q;
  // Dispatch pending after the current beat is shown.
  logic pend_q;
  logic [2:0] kind_q;
  logic [7:0] client_q;
  logic [1:0] worker_q;
  logic [21:0] x_q, y_q;
  logic [4:0] zoom_q;
  logic [15:0] code_q;
  logic last_q;

  dlrd_pkg::stk_ctrl_t ctrl;
  dlrd_pkg::entry_t top, din;
  logic hit_stack, clear, dup, accept;
  logic [NS-1:0] slot_hit;
  logic free_found;
  logic [dlrd_pkg::SlotW-1:0] free_slot;

  assign ready_o = (state_q == StIdle);
  assign accept = valid_i && ready_o;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      slot_hit[i] = alloc_q[i] && slot_tile_q[i].x == tile_x_i
                    && slot_tile_q[i].y == tile_y_i
                    && slot_tile_q[i].zoom == zoom_i;
    end
    dup = hit_stack || (|slot_hit);
    free_found = 1'b0;
    free_slot = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!alloc_q[i] || !busy_q[i]) begin
        free_found = 1'b1;
        free_slot = dlrd_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    din.marker = (command_i == dlrd_pkg::CmdMarker);
    din.zoom = din.marker ? 5'd0 : zoom_i;
    din.x = din.marker ? 22'd0 : tile_x_i;
    din.y = din.marker ? 22'd0 : tile_y_i;
    din.client = requester_i;
    ctrl.din = din;
    ctrl.push = accept && (command_i == dlrd_pkg::CmdMarker
                || (command_i == dlrd_pkg::CmdTile && !dup))
                && count_q != CW'(dlrd_pkg::StackDepth);
    ctrl.pop = (state_q == StDispatch) && count_q != '0 && free_found;
    clear = accept && command_i == dlrd_pkg::CmdClear;
  end

  dlrd_stack u_stack (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .clear_i(clear),
    .x_i(tile_x_i), .y_i(tile_y_i), .zoom_i(zoom_i),
    .top_o(top), .hit_o(hit_stack)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      alloc_q  <= '0;
      busy_q   <= '0;
      recv_q   <= '0;
      pend_q   <= 1'b0;
      kind_q   <= '0;
      client_q <= '0;
      worker_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      zoom_q   <= '0;
      code_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (command_i)
              dlrd_pkg::CmdTile, dlrd_pkg::CmdMarker: begin
                if (ctrl.push) begin
                  count_q <= count_q + CW'(1);
                  state_q <= StDispatch;
                end else if (command_i == dlrd_pkg::CmdMarker || !dup) begin
                  // Stack full: reject back to the requester.
                  kind_q   <= dlrd_pkg::KindRejected;
                  client_q <= requester_i;
                  worker_q <= '0;
                  x_q      <= '0;
                  y_q      <= '0;
                  zoom_q   <= '0;
                  code_q   <= '0;
                  last_q   <= 1'b1;
                  state_q  <= StOut;
                end
              end
              dlrd_pkg::CmdFinish, dlrd_pkg::CmdError, dlrd_pkg::CmdCancel: begin
                if (alloc_q[slot_index_i] && busy_q[slot_index_i]) begin
                  busy_q[slot_index_i] <= 1'b0;
                  client_q <= slot_tile_q[slot_index_i].client;
                  worker_q <= slot_index_i;
                  state_q  <= StOut;
                  if (command_i == dlrd_pkg::CmdFinish) begin
                    recv_q <= recv_q + 32'd1;
                    kind_q <= dlrd_pkg::KindReceived;
                    x_q    <= slot_tile_q[slot_index_i].x;
                    y_q    <= slot_tile_q[slot_index_i].y;
                    zoom_q <= slot_tile_q[slot_index_i].zoom;
                    code_q <= '0;
                    // Hold off last until the follow-on dispatch is known.
                    last_q <= 1'b0;
                    pend_q <= 1'b1;
                  end else if (command_i == dlrd_pkg::CmdError) begin
                    kind_q <= dlrd_pkg::KindError;
                    x_q    <= '0;
                    y_q    <= '0;
                    zoom_q <= '0;
                    code_q <= fault_code_i;
                    last_q <= 1'b1;
                  end else begin
                    kind_q <= dlrd_pkg::KindCancelled;
                    x_q    <= '0;
                    y_q    <= '0;
                    zoom_q <= '0;
                    code_q <= '0;
                    last_q <= 1'b1;
                  end
                end
              end
              dlrd_pkg::CmdClear: count_q <= '0;
              default: ;
            endcase
          end
        end
        StDispatch: begin
          if (ctrl.pop) begin
            count_q  <= count_q - CW'(1);
            client_q <= top.client;
            worker_q <= free_slot;
            code_q   <= '0;
            last_q   <= 1'b1;
            if (top.marker) begin
              kind_q <= dlrd_pkg::KindJobDone;
              x_q    <= '0;
              y_q    <= '0;
              zoom_q <= '0;
            end else begin
              kind_q <= dlrd_pkg::KindStarted;
              x_q    <= top.x;
              y_q    <= top.y;
              zoom_q <= top.zoom;
              alloc_q[free_slot] <= 1'b1;
              busy_q[free_slot]  <= 1'b1;
            end
            state_q <= StOut;
          end else begin
            state_q <= StIdle;
          end
        end
        StOut: begin
          if (ready_i) begin
            if (pend_q) begin
              pend_q <= 1'b0;
              // Advance to a dispatch only if one will really happen.
              if (count_q != '0 && free_found) begin
                state_q <= StDispatch;
              end else begin
                state_q <= StIdle;
              end
            end else begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // last on a finish beat must be known while it is shown.
  logic show_last;
  assign show_last = last_q || (pend_q && !(count_q != '0 && free_found));

  always_ff @(posedge clk_i) begin
    if (ctrl.pop && !top.marker) begin
      slot_tile_q[free_slot] <= top;
    end
  end

  assign valid_o          = (state_q == StOut);
  assign kind_o           = kind_q;
  assign client_o         = client_q;
  assign worker_o         = worker_q;
  assign out_x_o          = x_q;
  assign out_y_o          = y_q;
  assign out_zoom_o       = zoom_q;
  assign out_code_o       = code_q;
  assign received_total_o = recv_q;
  assign last_o           = show_last;
endmodule
